@@ hdl/rsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, character codes and types for the radix string parser.
// ----------------------------------------------------------------------------
package rsi_pkg;

    // Accumulator width and the string length (sign included) at which a string fails
    localparam int VALUE_BITS = 64;
    localparam int MAX_CHARS  = 65;
    localparam int OUT_BITS   = 64;
    localparam int POS_W      = $clog2(MAX_CHARS + 1);
    localparam int PROD_W     = VALUE_BITS + 7;

    // Base limits and character codes
    localparam logic [7:0] RADIX_RESET = 8'd10;
    localparam logic [7:0] RADIX_MIN   = 8'd2;
    localparam logic [7:0] RADIX_MAX   = 8'd36;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5A;
    localparam logic [7:0] CH_LO_A     = 8'h61;
    localparam logic [7:0] CH_LO_Z     = 8'h7A;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    // Decoded character, carried in the input stage
    typedef struct packed {
        logic       is_nul;
        logic       is_sign;
        logic       is_minus;
        logic       dig_ok;
        logic [5:0] dig_val;
    } char_info_t;

    // One finished string
    typedef struct packed {
        logic signed [OUT_BITS-1:0] value;
        logic                       ok;
    } parse_result_t;

    // True when x survives truncation to the accumulator width
    function automatic logic fits_value(input logic signed [PROD_W-1:0] x);
        logic signed [VALUE_BITS-1:0] t;
        t = x[VALUE_BITS-1:0];
        return (PROD_W'(t) == x);
    endfunction

endpackage

@@ hdl/rsi_digit_dec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_digit_dec
// Classifies one character: terminator, sign, or digit value in the base.
// ----------------------------------------------------------------------------
module rsi_digit_dec
(
    input  logic [7:0]          ch,
    input  logic [7:0]          radix,
    output rsi_pkg::char_info_t info
);

    logic       base_ok;
    logic       is_alnum;
    logic [7:0] raw_val;

    always_comb
    begin
        base_ok = (radix >= rsi_pkg::RADIX_MIN) && (radix <= rsi_pkg::RADIX_MAX);

        // Map 0-9, A-Z and a-z onto digit values
        is_alnum = 1'b1;
        priority if ((ch >= rsi_pkg::CH_ZERO) && (ch <= rsi_pkg::CH_NINE))
        begin
            raw_val = ch - rsi_pkg::CH_ZERO;
        end
        else if ((ch >= rsi_pkg::CH_UP_A) && (ch <= rsi_pkg::CH_UP_Z))
        begin
            raw_val = ch - rsi_pkg::CH_UP_A + rsi_pkg::LETTER_BASE;
        end
        else if ((ch >= rsi_pkg::CH_LO_A) && (ch <= rsi_pkg::CH_LO_Z))
        begin
            raw_val = ch - rsi_pkg::CH_LO_A + rsi_pkg::LETTER_BASE;
        end
        else
        begin
            raw_val  = '0;
            is_alnum = 1'b0;
        end

        info.is_nul   = (ch == rsi_pkg::CH_NUL);
        info.is_sign  = (ch == rsi_pkg::CH_PLUS) || (ch == rsi_pkg::CH_MINUS);
        info.is_minus = (ch == rsi_pkg::CH_MINUS);
        info.dig_ok   = base_ok && is_alnum && (raw_val < radix);
        info.dig_val  = raw_val[5:0];
    end

endmodule

@@ hdl/rsi_parse_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_parse_core
// Per-string state: accumulator, position, sign and sticky error flag.
// ----------------------------------------------------------------------------
module rsi_parse_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  rsi_pkg::char_info_t    info,
    input  logic [7:0]             radix,
    output rsi_pkg::parse_result_t result
);

    logic signed [rsi_pkg::VALUE_BITS-1:0] acc_reg, acc_next;
    logic [rsi_pkg::POS_W-1:0]             pos_reg, pos_next;
    logic                                  neg_reg, neg_next;
    logic                                  sign_reg, sign_next;
    logic                                  failed_reg, failed_next;

    logic                                  fail_now;
    logic                                  fail_end;
    logic signed [rsi_pkg::PROD_W-1:0]     acc_w;
    logic signed [rsi_pkg::PROD_W-1:0]     rad_w;
    logic signed [rsi_pkg::PROD_W-1:0]     dig_w;
    logic signed [rsi_pkg::PROD_W-1:0]     prod;
    logic signed [rsi_pkg::PROD_W-1:0]     sum;

    // Scale by the base and fold in the digit at full width
    always_comb
    begin
        acc_w = rsi_pkg::PROD_W'(acc_reg);
        rad_w = rsi_pkg::PROD_W'(radix[5:0]);
        dig_w = rsi_pkg::PROD_W'(info.dig_val);
        prod  = acc_w * rad_w;
        sum   = neg_reg ? (prod - dig_w) : (prod + dig_w);
    end

    // Next state and the result for a terminator
    always_comb
    begin
        fail_now = failed_reg || (pos_reg >= rsi_pkg::POS_W'(rsi_pkg::MAX_CHARS));
        fail_end = fail_now || (pos_reg == '0)
                   || (sign_reg && (pos_reg == rsi_pkg::POS_W'(1)));

        result.ok    = !fail_end;
        result.value = fail_end ? '0 : rsi_pkg::OUT_BITS'(acc_reg);

        acc_next    = acc_reg;
        neg_next    = neg_reg;
        sign_next   = sign_reg;
        failed_next = fail_now;
        pos_next    = (pos_reg < rsi_pkg::POS_W'(rsi_pkg::MAX_CHARS))
                      ? pos_reg + rsi_pkg::POS_W'(1) : pos_reg;

        if (info.is_nul)
        begin
            // Clear for the next string
            acc_next    = '0;
            neg_next    = 1'b0;
            sign_next   = 1'b0;
            failed_next = 1'b0;
            pos_next    = '0;
        end
        else if (!fail_now)
        begin
            priority if ((pos_reg == '0) && info.is_sign)
            begin
                sign_next = 1'b1;
                neg_next  = info.is_minus;
            end
            else if (!info.dig_ok)
            begin
                failed_next = 1'b1;
            end
            else if (pos_reg == '0)
            begin
                acc_next = rsi_pkg::VALUE_BITS'(info.dig_val);
            end
            else if (!rsi_pkg::fits_value(prod) || !rsi_pkg::fits_value(sum))
            begin
                failed_next = 1'b1;
            end
            else
            begin
                acc_next = sum[rsi_pkg::VALUE_BITS-1:0];
            end
        end
    end

    // Hold string state between characters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            pos_reg    <= '0;
            neg_reg    <= 1'b0;
            sign_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end
        else if (step)
        begin
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            neg_reg    <= neg_next;
            sign_reg   <= sign_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ hdl/radix_string_to_integer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_string_to_integer_top
// Parses a NUL-terminated ASCII stream into a signed integer in base 2..36.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless a terminator waits for a free result
//   register; the accumulator update is one multiply-add by the base through the
//   input stage and the state registers. A terminator in the input stage loads the
//   result register once the pending result beat, if any, has been taken.
// Reset: radix returns to 10, string state clears, no result pending.
// ----------------------------------------------------------------------------
module radix_string_to_integer_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         radix,
    input  logic               ch_valid,
    output logic               ch_ready,
    input  logic [7:0]         ch,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] value,
    output logic               ok
);

    logic [7:0]             radix_reg;
    rsi_pkg::char_info_t    dec_info;
    rsi_pkg::char_info_t    s1_info_reg;
    logic                   s1_valid_reg;
    rsi_pkg::parse_result_t core_result;
    rsi_pkg::parse_result_t res_reg;
    logic                   out_valid_reg;
    logic                   out_free;
    logic                   step;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rsi_pkg::RADIX_RESET;
        end
        else if (cfg_valid)
        begin
            radix_reg <= radix;
        end
    end

    // Decode the incoming beat
    rsi_digit_dec u_dec
    (
        .ch    (ch),
        .radix (radix_reg),
        .info  (dec_info)
    );

    // Advance the input stage; only a terminator needs room at the output
    assign out_free = !out_valid_reg || out_ready;
    assign step     = s1_valid_reg && (!s1_info_reg.is_nul || out_free);
    assign ch_ready = !s1_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ch_ready)
        begin
            s1_valid_reg <= ch_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ch_ready && ch_valid)
        begin
            s1_info_reg <= dec_info;
        end
    end

    rsi_parse_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .info   (s1_info_reg),
        .radix  (radix_reg),
        .result (core_result)
    );

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && s1_info_reg.is_nul)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_info_reg.is_nul)
        begin
            res_reg <= core_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = res_reg.value;
    assign ok        = res_reg.ok;

endmodule

@@ test/tb_radix_string_to_integer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_string_to_integer_top
// Checks the radix string parser against a cycle-free behavioural copy of
// the parser. Strings are queued as characters and sent with random gaps;
// each terminator yields an expected value and ok flag, matched in order
// against the result beats. The base register is changed between runs of
// strings, including the invalid extremes and once in the middle of a string.
// ----------------------------------------------------------------------------
module tb_radix_string_to_integer_top;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;

    localparam logic [63:0] ACC_MAX_BITS =
        (64'd1 << (rsi_pkg::VALUE_BITS - 1)) - 64'd1;
    localparam longint      ACC_MAX      = longint'(ACC_MAX_BITS);
    localparam longint      ACC_MIN      = -ACC_MAX - 1;
    localparam logic [63:0] HALF_RANGE   = 64'h8000_0000_0000_0000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         radix     = rsi_pkg::RADIX_RESET;
    logic               ch_valid  = 1'b0;
    logic               ch_ready;
    logic [7:0]         ch        = rsi_pkg::CH_NUL;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [63:0] value;
    logic               ok;

    // Characters waiting to be sent and parses waiting to come out
    logic [7:0]             pending_chars[$];
    rsi_pkg::parse_result_t awaited_parses[$];
    rsi_pkg::parse_result_t next_parse;
    rsi_pkg::parse_result_t want;

    // Parser state as the block should hold it
    logic [7:0] radix_setting = rsi_pkg::RADIX_RESET;
    longint     str_acc       = 0;
    int         str_pos       = 0;
    bit         str_neg       = 1'b0;
    bit         str_signed    = 1'b0;
    bit         str_failed    = 1'b0;

    int send_idle_pct = 14;
    int recv_idle_pct = 66;
    int queued_chars  = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;
    int hold_count    = 0;
    bit hold_armed    = 1'b0;
    bit hold_done     = 1'b0;

    radix_string_to_integer_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .radix     (radix),
        .ch_valid  (ch_valid),
        .ch_ready  (ch_ready),
        .ch        (ch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .ok        (ok)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Advance the parser by one character; return 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c,
                                      output rsi_pkg::parse_result_t res);
        longint d;
        longint b;
        res = '0;
        if (str_pos >= rsi_pkg::MAX_CHARS)
            str_failed = 1'b1;

        // Terminator: emit and start afresh
        if (c == rsi_pkg::CH_NUL)
        begin
            if (str_pos == 0)
                str_failed = 1'b1;
            if (str_signed && str_pos == 1)
                str_failed = 1'b1;
            if (!str_failed)
            begin
                res.value = str_acc;
                res.ok    = 1'b1;
            end
            str_acc    = 0;
            str_pos    = 0;
            str_neg    = 1'b0;
            str_signed = 1'b0;
            str_failed = 1'b0;
            return 1'b1;
        end

        if (!str_failed)
        begin
            if (str_pos == 0 && (c == rsi_pkg::CH_PLUS || c == rsi_pkg::CH_MINUS))
            begin
                str_signed = 1'b1;
                str_neg    = (c == rsi_pkg::CH_MINUS);
            end
            else
            begin
                // Decode the digit; -1 marks a character outside the base
                b = longint'(radix_setting);
                if (radix_setting < rsi_pkg::RADIX_MIN || radix_setting > rsi_pkg::RADIX_MAX)
                    d = -1;
                else if (c >= rsi_pkg::CH_ZERO && c <= rsi_pkg::CH_NINE)
                    d = longint'(c - rsi_pkg::CH_ZERO);
                else if (c >= rsi_pkg::CH_UP_A && c <= rsi_pkg::CH_UP_Z)
                    d = longint'(c - rsi_pkg::CH_UP_A) + 10;
                else if (c >= rsi_pkg::CH_LO_A && c <= rsi_pkg::CH_LO_Z)
                    d = longint'(c - rsi_pkg::CH_LO_A) + 10;
                else
                    d = -1;
                if (d >= b)
                    d = -1;

                if (d < 0)
                    str_failed = 1'b1;
                else if (str_pos == 0)
                    str_acc = d;
                else if (str_acc > 0 && str_acc > ACC_MAX / b)
                    str_failed = 1'b1;
                else if (str_acc < 0 && str_acc < ACC_MIN / b)
                    str_failed = 1'b1;
                else
                begin
                    str_acc = str_acc * b;
                    if (str_neg)
                    begin
                        if (str_acc < ACC_MIN + d)
                            str_failed = 1'b1;
                        else
                            str_acc = str_acc - d;
                    end
                    else
                    begin
                        if (str_acc > ACC_MAX - d)
                            str_failed = 1'b1;
                        else
                            str_acc = str_acc + d;
                    end
                end
            end
        end

        if (str_pos < rsi_pkg::MAX_CHARS)
            str_pos++;
        return 1'b0;
    endfunction

    // Character driver: predict on each beat taken, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid <= 1'b0;
            ch       <= rsi_pkg::CH_NUL;
        end
        else
        begin
            if (ch_valid && ch_ready)
            begin
                if (parse_char(ch, next_parse))
                    awaited_parses.push_back(next_parse);
            end
            if (!ch_valid || ch_ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    ch_valid <= 1'b1;
                    ch       <= pending_chars.pop_front();
                end
                else
                    ch_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each beat with the oldest parse due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_parses.size() == 0)
                begin
                    $error("unexpected result beat: value %0d ok %0b", value, ok);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = awaited_parses.pop_front();
                    if (value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d", want.value, value);
                        mismatches = mismatches + 1;
                    end
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0b, actual %0b", want.ok, ok);
                        mismatches = mismatches + 1;
                    end
                end
            end

            // Hold off once for a long stretch, otherwise stall at random
            if (hold_armed && !hold_done)
            begin
                out_ready  <= 1'b0;
                hold_count <= hold_count + 1;
                if (hold_count == HOLD_CYCLES - 1)
                    hold_done <= 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (ch_valid && ch_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic void queue_char(input logic [7:0] c);
        pending_chars.push_back(c);
        queued_chars++;
    endfunction

    function automatic logic [7:0] digit_char(input int d, input bit upper);
        if (d < 10)
            return rsi_pkg::CH_ZERO + 8'(d);
        return (upper ? rsi_pkg::CH_UP_A : rsi_pkg::CH_LO_A) + 8'(d - 10);
    endfunction

    // Queue a literal string and its terminator
    function automatic void queue_text(input string s);
        foreach (s[i])
            queue_char(s[i]);
        queue_char(rsi_pkg::CH_NUL);
    endfunction

    // Queue a magnitude written in the given base, with sign and terminator
    function automatic void queue_number(input logic [63:0] mag, input bit neg,
                                         input int base);
        logic [7:0] digits[$];
        do
        begin
            digits.push_front(digit_char(int'(mag % 64'(base)), $urandom_range(1)));
            mag = mag / 64'(base);
        end
        while (mag != 0);
        if (neg)
            queue_char(rsi_pkg::CH_MINUS);
        else if ($urandom_range(3) == 0)
            queue_char(rsi_pkg::CH_PLUS);
        foreach (digits[i])
            queue_char(digits[i]);
        queue_char(rsi_pkg::CH_NUL);
    endfunction

    // One random string, mostly well formed, the rest noise and broken forms
    function automatic void queue_random_string();
        int          kind;
        int          len;
        int          spot;
        int          base;
        logic [63:0] mag;
        kind = $urandom_range(99);
        base = (radix_setting >= rsi_pkg::RADIX_MIN && radix_setting <= rsi_pkg::RADIX_MAX)
               ? int'(radix_setting) : 36;
        if (kind < 60)
        begin
            // random digits, now and then long enough to overflow
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
            case ($urandom_range(3))
                0:       queue_char(rsi_pkg::CH_PLUS);
                1:       queue_char(rsi_pkg::CH_MINUS);
                default: ;
            endcase
            repeat (len)
                queue_char(digit_char($urandom_range(base - 1), $urandom_range(1)));
            queue_char(rsi_pkg::CH_NUL);
        end
        else if (kind < 75)
        begin
            // values around the signed limits or spread over the range
            case ($urandom_range(2))
                0:       mag = HALF_RANGE + 64'($urandom_range(6)) - 64'd3;
                1:       mag = {$urandom, $urandom};
                default: mag = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            queue_number(mag, $urandom_range(1), base);
        end
        else if (kind < 85)
        begin
            // arbitrary bytes
            len = $urandom_range(8);
            repeat (len)
                queue_char(8'($urandom_range(1, 255)));
            queue_char(rsi_pkg::CH_NUL);
        end
        else if (kind < 90)
        begin
            // empty string or a sign alone
            case ($urandom_range(2))
                0:       ;
                1:       queue_char(rsi_pkg::CH_PLUS);
                default: queue_char(rsi_pkg::CH_MINUS);
            endcase
            queue_char(rsi_pkg::CH_NUL);
        end
        else if (kind < 95)
        begin
            // good digits with one stray character dropped in
            len  = $urandom_range(2, 10);
            spot = $urandom_range(len - 1);
            for (int i = 0; i < len; i++)
            begin
                if (i == spot)
                begin
                    case ($urandom_range(2))
                        0:       queue_char(rsi_pkg::CH_PLUS);
                        1:       queue_char(rsi_pkg::CH_MINUS);
                        default: queue_char(8'($urandom_range(1, 255)));
                    endcase
                end
                queue_char(digit_char($urandom_range(base - 1), $urandom_range(1)));
            end
            queue_char(rsi_pkg::CH_NUL);
        end
        else
        begin
            // lengths around the character limit, padded with zeros
            len = $urandom_range(rsi_pkg::MAX_CHARS - 3, rsi_pkg::MAX_CHARS + 2);
            if ($urandom_range(1))
            begin
                queue_char($urandom_range(1) ? rsi_pkg::CH_PLUS : rsi_pkg::CH_MINUS);
                len--;
            end
            repeat (len - 3)
                queue_char(rsi_pkg::CH_ZERO);
            repeat (3)
                queue_char(digit_char($urandom_range(base - 1), $urandom_range(1)));
            queue_char(rsi_pkg::CH_NUL);
        end
    endfunction

    // Wait until every character is sent and every parse has come out;
    // look between edges so that the driver's updates have settled
    task automatic drain();
        @(negedge clk);
        while (pending_chars.size() != 0 || ch_valid || awaited_parses.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_radix(input logic [7:0] r);
        drain();
        cfg_valid <= 1'b1;
        radix     <= r;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        radix_setting  = r;
    endtask

    task automatic random_phase(input logic [7:0] r, input int n_chars);
        int goal;
        write_radix(r);
        goal = queued_chars + n_chars;
        while (queued_chars < goal)
            queue_random_string();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings in the reset base
        queue_char(rsi_pkg::CH_NUL);
        queue_text("+");
        queue_text("-");
        queue_text("-0");
        queue_number(ACC_MAX_BITS, 1'b0, 10);
        queue_number(HALF_RANGE, 1'b1, 10);
        queue_text("9223372036854775808");
        queue_text("-9223372036854775809");
        queue_text("92233720368547758070");
        queue_text("1-2");
        queue_text("++1");
        queue_text("12a");
        queue_char(8'd55);
        queue_char(8'hFF);
        queue_char(rsi_pkg::CH_NUL);
        queue_char(8'h80);
        queue_text("1");
        queue_text("x123");
        repeat (64) queue_char(rsi_pkg::CH_ZERO);
        queue_char(rsi_pkg::CH_NUL);
        repeat (65) queue_char(rsi_pkg::CH_ZERO);
        queue_char(rsi_pkg::CH_NUL);
        queue_text("5");

        // Change the base halfway through a string
        queue_char(8'd49);
        write_radix(8'd16);
        queue_text("f");
        queue_text("7fffffffffffffff");
        queue_text("-8000000000000000");
        queue_text("8000000000000000");
        queue_text("+FfAa09");
        queue_text("g");

        write_radix(rsi_pkg::RADIX_MAX);
        queue_text("zZ");
        queue_text("ZZZZZZZZZZZZZ");
        write_radix(rsi_pkg::RADIX_MIN);
        queue_number(ACC_MAX_BITS, 1'b0, 2);
        queue_number(HALF_RANGE, 1'b1, 2);
        queue_text("2");
        write_radix(8'd0);
        queue_text("0");
        write_radix(8'd255);
        queue_text("1");

        // Sender idles lightly, receiver heavily
        random_phase(8'd10, 120);
        random_phase(rsi_pkg::RADIX_MIN, 120);
        random_phase(rsi_pkg::RADIX_MAX, 100);
        random_phase(8'd0, 40);

        // Sender idles heavily, receiver lightly
        drain();
        send_idle_pct = 66;
        recv_idle_pct = 14;
        random_phase(8'd16, 100);
        random_phase(8'd8, 80);
        random_phase(8'd255, 40);
        random_phase(8'd3, 80);
        random_phase(8'($urandom_range(2, 36)), 100);

        // No idling on either side
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(8'd37, 30);
        random_phase(8'd1, 30);
        random_phase(8'd7, 60);
        random_phase(8'($urandom_range(2, 36)), 100);

        // Back-pressure: receiver holds off while characters keep coming
        drain();
        hold_armed = 1'b1;
        random_phase(8'd10, 150);

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
